/* sv/lbs_pkg.sv */
package lbs_pkg;

    // step table geometry
    localparam int STEP_DEPTH = 32;
    localparam int STEP_AW    = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
    localparam int STEP_CW    = $clog2(STEP_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PRESENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PRESENT = 2'd2;

    // command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_LIGHT = 3'd4;

    // led selector codes
    localparam logic [1:0] SEL_OFF = 2'd0;
    localparam logic [1:0] SEL_A   = 2'd1;
    localparam logic [1:0] SEL_B   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  led_select;
        logic [15:0] duration;
        logic [15:0] repeats;
    } t_in_item;

    typedef struct packed {
        logic       out_a;
        logic       out_b;
        logic       active;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  target;
        logic [15:0] length;
    } t_step;

    typedef struct packed {
        logic on_level;
        logic first_present;
        logic second_present;
    } t_cfg;

    typedef struct packed {
        logic               busy;
        logic               playing;
        logic [STEP_CW-1:0] count;
    } t_seq_stat;

endpackage

/* sv/led_blink_step_sequencer.sv */
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in  (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item at a time. Add, clear, light, unknown commands and stopped ticks go from
// S_IDLE to S_EMIT; an accepted start reads the table once in S_START_RD, and a playing tick reads
// it in S_TICK_RD (the step's length) and, when it moves to another step, again in
// S_NEXT_RD (that step's target), over the single read port. Reset clears the control
// state; the step table is not cleared, only entries below the step count are ever
// read. A result waits in the output register while the next item is taken; the block
// stalls only when a second result is ready and the first has not been taken.
module led_blink_step_sequencer import lbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    t_cfg               cfg;
    t_seq_stat          stat;
    logic               ram_we;
    logic [STEP_AW-1:0] ram_waddr;
    logic [STEP_AW-1:0] ram_raddr;
    t_step              ram_wdata;
    t_step              ram_rdata;

    // configuration registers
    lbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // step table
    lbs_step_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    lbs_seq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_stat      (stat)
    );

`ifndef SYNTHESIS
    // an accepted item always makes the sequencer busy and drops input ready
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (stat.busy && !o_in_ready))
        else $error("input taken again right after a transfer");

    // playback needs a non-empty table
    a_play_needs_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.playing |-> (stat.count != '0))
        else $error("playing with an empty step table");

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= STEP_CW'(STEP_DEPTH))
        else $error("step count beyond table depth");

    // the active flag of a result matches playback at the time it was produced
    a_active_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) && stat.busy && !o_in_ready
        |=> (!o_out_valid || !$rose(o_out_valid) || (o_out.active == $past(stat.playing))))
        else $error("result active flag does not match playback state");
`endif

endmodule

/* sv/lbs_step_ram.sv */
module lbs_step_ram import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [STEP_AW-1:0] i_waddr,
    input  t_step              i_wdata,
    input  logic [STEP_AW-1:0] i_raddr,
    output t_step              o_rdata
);

    t_step r_mem [STEP_DEPTH];
    t_step r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lbs_cfg_regs.sv */
module lbs_cfg_regs import lbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    // register decode, writes beyond the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ON_LEVEL:       n_cfg.on_level       = i_cfg_data;
                CFG_FIRST_PRESENT:  n_cfg.first_present  = i_cfg_data;
                CFG_SECOND_PRESENT: n_cfg.second_present = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{on_level: 1'b1, first_present: 1'b1, second_present: 1'b1};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/lbs_seq_ctrl.sv */
module lbs_seq_ctrl import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    output logic               o_ram_we,
    output logic [STEP_AW-1:0] o_ram_waddr,
    output t_step              o_ram_wdata,
    output logic [STEP_AW-1:0] o_ram_raddr,
    input  t_step              i_ram_rdata,
    output t_seq_stat          o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_RD,
        S_TICK_RD,
        S_NEXT_RD,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_CW-1:0] r_count, n_count;
    logic [STEP_AW-1:0] r_cur, n_cur;
    logic               r_playing, n_playing;
    logic [15:0]        r_passes, n_passes;
    logic [15:0]        r_elapsed, n_elapsed;
    logic [1:0]         r_lit, n_lit;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [STEP_CW-1:0] nxt;
    logic               out_free;
    logic               a_lit;
    logic               b_lit;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign a_lit      = (r_lit == SEL_A) && i_cfg.first_present;
    assign b_lit      = (r_lit == SEL_B) && i_cfg.second_present;
    assign nxt        = STEP_CW'(r_cur) + STEP_CW'(1);

    // table write side
    assign o_ram_waddr = r_count[STEP_AW-1:0];
    assign o_ram_wdata = '{target: i_in.led_select, length: i_in.duration};

    // sequencer: read, compare, write back
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_playing   = r_playing;
        n_passes    = r_passes;
        n_elapsed   = r_elapsed;
        n_lit       = r_lit;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ram_we    = 1'b0;
        o_ram_raddr = r_cur;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                    case (i_in.command)
                        CMD_ADD: begin
                            if (r_count >= STEP_CW'(STEP_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we = 1'b1;
                                n_count  = r_count + STEP_CW'(1);
                            end
                        end
                        CMD_CLEAR, CMD_LIGHT: begin
                            n_count   = '0;
                            n_cur     = '0;
                            n_playing = 1'b0;
                            n_passes  = '0;
                            n_elapsed = '0;
                            n_lit     = (i_in.command == CMD_LIGHT) ? i_in.led_select : SEL_OFF;
                        end
                        CMD_START: begin
                            if (i_in.repeats == '0 || r_count == '0) begin
                                n_status = ST_IGNORED;
                            end else begin
                                n_playing   = 1'b1;
                                n_cur       = '0;
                                n_passes    = i_in.repeats - 16'd1;
                                n_elapsed   = '0;
                                o_ram_raddr = '0;
                                n_state     = S_START_RD;
                            end
                        end
                        CMD_TICK: begin
                            if (r_playing && r_count != '0) begin
                                if (r_elapsed != 16'hFFFF) begin
                                    n_elapsed = r_elapsed + 16'd1;
                                end
                                n_state = S_TICK_RD;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_START_RD: begin
                n_lit   = i_ram_rdata.target;
                n_state = S_EMIT;
            end
            S_TICK_RD: begin
                n_state = S_EMIT;
                if (r_elapsed >= i_ram_rdata.length) begin
                    if (nxt >= r_count && r_passes == '0) begin
                        // last pass done
                        n_count   = '0;
                        n_cur     = '0;
                        n_playing = 1'b0;
                        n_passes  = '0;
                        n_elapsed = '0;
                        n_lit     = SEL_OFF;
                    end else if (nxt >= r_count) begin
                        n_passes    = r_passes - 16'd1;
                        n_cur       = '0;
                        o_ram_raddr = '0;
                        n_state     = S_NEXT_RD;
                    end else begin
                        n_cur       = nxt[STEP_AW-1:0];
                        o_ram_raddr = nxt[STEP_AW-1:0];
                        n_state     = S_NEXT_RD;
                    end
                end
            end
            S_NEXT_RD: begin
                n_lit     = i_ram_rdata.target;
                n_elapsed = '0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.out_a  = a_lit ? i_cfg.on_level : ~i_cfg.on_level;
                    n_out.out_b  = b_lit ? i_cfg.on_level : ~i_cfg.on_level;
                    n_out.active = r_playing;
                    n_out.status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_playing   <= 1'b0;
            r_passes    <= '0;
            r_elapsed   <= '0;
            r_lit       <= SEL_OFF;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_playing   <= n_playing;
            r_passes    <= n_passes;
            r_elapsed   <= n_elapsed;
            r_lit       <= n_lit;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_stat      = '{busy: (r_state != S_IDLE), playing: r_playing, count: r_count};

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import lbs_pkg::*;

    // command and selector codes outside the documented set
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [1:0] SEL_NONE     = 2'd3;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 50;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ON_LEVEL;
    logic                 i_cfg_data  = 1'b0;

    // predicted sequencer state
    t_step       pat_table [STEP_DEPTH];
    int          pat_count;
    int          cur_idx;
    logic        seq_playing;
    logic [15:0] passes_rem;
    logic [15:0] tick_count;
    logic [1:0]  lit_sel;
    t_cfg        led_cfg;

    t_out_item   led_expect_q[$];
    int          err_count      = 0;
    int          items_sent     = 0;
    bit          idling_on      = 1'b0;
    int          out_stall_left = 0;

    led_blink_step_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // abandon the run if it hangs
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // predictor: stop playback and switch everything off
    function automatic void drop_sequence();
        pat_count   = 0;
        cur_idx     = 0;
        seq_playing = 1'b0;
        passes_rem  = '0;
        tick_count  = '0;
        lit_sel     = SEL_OFF;
    endfunction

    // predictor: one millisecond tick
    function automatic void advance_tick();
        int nxt;
        if (!seq_playing || pat_count == 0) begin
            return;
        end
        if (tick_count != 16'hFFFF) begin
            tick_count = tick_count + 16'd1;
        end
        if (tick_count < pat_table[cur_idx].length) begin
            return;
        end
        nxt = cur_idx + 1;
        if (nxt >= pat_count) begin
            if (passes_rem != 0) begin
                passes_rem = passes_rem - 16'd1;
                nxt        = 0;
            end else begin
                drop_sequence();
                return;
            end
        end
        cur_idx    = nxt;
        lit_sel    = pat_table[nxt].target;
        tick_count = '0;
    endfunction

    // predictor: apply one command and give the resulting output levels
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item  res;
        logic [1:0] st;
        st = ST_OK;
        case (it.command)
            CMD_ADD: begin
                if (pat_count >= STEP_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    pat_table[pat_count].target = it.led_select;
                    pat_table[pat_count].length = it.duration;
                    pat_count++;
                end
            end
            CMD_CLEAR: begin
                drop_sequence();
            end
            CMD_START: begin
                if (it.repeats == 0 || pat_count == 0) begin
                    st = ST_IGNORED;
                end else begin
                    seq_playing = 1'b1;
                    cur_idx     = 0;
                    passes_rem  = it.repeats - 16'd1;
                    tick_count  = '0;
                    lit_sel     = pat_table[0].target;
                end
            end
            CMD_TICK: begin
                advance_tick();
            end
            CMD_LIGHT: begin
                drop_sequence();
                lit_sel = it.led_select;
            end
            default: begin
            end
        endcase
        res.out_a  = (lit_sel == SEL_A && led_cfg.first_present) ?
                     led_cfg.on_level : ~led_cfg.on_level;
        res.out_b  = (lit_sel == SEL_B && led_cfg.second_present) ?
                     led_cfg.on_level : ~led_cfg.on_level;
        res.active = seq_playing;
        res.status = st;
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] cmd, input logic [1:0] sel,
                                           input logic [15:0] dur, input logic [15:0] rep);
        t_in_item it;
        it.command    = cmd;
        it.led_select = sel;
        it.duration   = dur;
        it.repeats    = rep;
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    // track configuration and input transfers, check each result transfer
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ON_LEVEL:       led_cfg.on_level       = i_cfg_data;
                    CFG_FIRST_PRESENT:  led_cfg.first_present  = i_cfg_data;
                    CFG_SECOND_PRESENT: led_cfg.second_present = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                led_expect_q = {led_expect_q, apply_command(i_in)};
            end
            if (o_out_valid && i_out_ready) begin
                if (led_expect_q.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = led_expect_q.pop_front();
                    if (o_out.out_a !== want.out_a) begin
                        report_mismatch($sformatf("out_a %b, expected %b",
                                                  o_out.out_a, want.out_a));
                    end
                    if (o_out.out_b !== want.out_b) begin
                        report_mismatch($sformatf("out_b %b, expected %b",
                                                  o_out.out_b, want.out_b));
                    end
                    if (o_out.active !== want.active) begin
                        report_mismatch($sformatf("active %b, expected %b",
                                                  o_out.active, want.active));
                    end
                    if (o_out.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_out.status, want.status));
                    end
                end
            end
        end
    end

    // result side back-pressure in bursts of random length, only while idling_on is set
    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left <= out_stall_left - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            i_out_ready    <= 1'b0;
            out_stall_left <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // offer one command, with an occasional gap first; valid stays high afterwards
    task automatic send_item(input t_in_item it);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (led_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers as back-to-back transfers
    task automatic write_config(input logic on_lvl, input logic a_on, input logic b_on);
        logic [CFG_IDX_W-1:0] idx [3];
        logic                 val [3];
        idx = '{CFG_ON_LEVEL, CFG_FIRST_PRESENT, CFG_SECOND_PRESENT};
        val = '{on_lvl, a_on, b_on};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] any_sel();
        return 2'($urandom_range(SEL_OFF, SEL_NONE));
    endfunction

    // field extremes, every command and the corner cases at reset settings
    task automatic test_directed_cases();
        idling_on <= 1'b1;
        send_item(make_item(CMD_TICK, SEL_A, 16'hFFFF, 16'hFFFF));
        send_item(make_item(CMD_START, SEL_B, 16'h0000, 16'd5));
        send_item(make_item(CMD_ADD, SEL_A, 16'd0, 16'h0000));
        send_item(make_item(CMD_ADD, SEL_B, 16'hFFFF, 16'hFFFF));
        send_item(make_item(CMD_ADD, SEL_NONE, 16'd1, 16'h5A5A));
        send_item(make_item(CMD_ADD, SEL_OFF, 16'd2, 16'hA5A5));
        send_item(make_item(CMD_START, SEL_A, 16'hFFFF, 16'd0));
        send_item(make_item(CMD_START, SEL_OFF, 16'h0000, 16'hFFFF));
        // zero length step ends at once, then a very long step
        send_item(make_item(CMD_TICK, SEL_OFF, 16'h0000, 16'h0000));
        send_item(make_item(CMD_TICK, SEL_NONE, 16'h1234, 16'h4321));
        // restart while playing
        send_item(make_item(CMD_START, SEL_OFF, 16'h0000, 16'd1));
        send_item(make_item(CMD_TICK, SEL_OFF, 16'h0000, 16'h0000));
        send_item(make_item(CMD_CLEAR, SEL_NONE, 16'hFFFF, 16'hFFFF));
        // step appended during playback joins the sequence
        send_item(make_item(CMD_ADD, SEL_A, 16'd1, 16'h0000));
        send_item(make_item(CMD_ADD, SEL_B, 16'd0, 16'h0000));
        send_item(make_item(CMD_START, SEL_OFF, 16'h0000, 16'd1));
        send_item(make_item(CMD_ADD, SEL_OFF, 16'd1, 16'h0000));
        repeat (3) send_item(make_item(CMD_TICK, SEL_OFF, 16'h0000, 16'h0000));
        send_item(make_item(CMD_LIGHT, SEL_A, 16'h0000, 16'h0000));
        send_item(make_item(CMD_LIGHT, SEL_B, 16'hFFFF, 16'hFFFF));
        send_item(make_item(CMD_LIGHT, SEL_NONE, 16'h0000, 16'h0000));
        send_item(make_item(CMD_LIGHT, SEL_OFF, 16'h0000, 16'h0000));
        send_item(make_item(CMD_SPARE_LO, SEL_A, 16'hFFFF, 16'hFFFF));
        send_item(make_item(CMD_SPARE_HI, SEL_B, 16'h0000, 16'h0000));
    endtask

    // every polarity and presence setting against lit and playing outputs
    task automatic test_output_levels();
        for (int c = 0; c < 8; c++) begin
            drain_results();
            write_config(c[2], c[1], c[0]);
            send_item(make_item(CMD_LIGHT, SEL_A, 16'($urandom), 16'($urandom)));
            send_item(make_item(CMD_LIGHT, SEL_B, 16'($urandom), 16'($urandom)));
            send_item(make_item(CMD_LIGHT, SEL_NONE, 16'($urandom), 16'($urandom)));
            send_item(make_item(CMD_ADD, SEL_A, 16'd1, 16'($urandom)));
            send_item(make_item(CMD_ADD, SEL_B, 16'd0, 16'($urandom)));
            send_item(make_item(CMD_START, any_sel(), 16'($urandom), 16'd1));
            repeat (2) send_item(make_item(CMD_TICK, any_sel(), 16'($urandom),
                                           16'($urandom)));
            send_item(make_item(CMD_LIGHT, SEL_OFF, 16'($urandom), 16'($urandom)));
        end
    endtask

    // one well-formed program (fill, start, ticks) or a single noise item
    task automatic run_program();
        int          n_steps;
        int          reps;
        longint      span;
        longint      n_ticks;
        logic [15:0] dur;
        if ($urandom_range(0, 6) == 0) begin
            send_item(make_item(3'($urandom_range(CMD_ADD, CMD_SPARE_HI)), any_sel(),
                                16'($urandom), 16'($urandom)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item(make_item(CMD_LIGHT, any_sel(), 16'($urandom), 16'($urandom)));
        end else begin
            send_item(make_item(CMD_CLEAR, any_sel(), 16'($urandom), 16'($urandom)));
        end
        // mostly short tables, sometimes up to and past full
        n_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(STEP_DEPTH - 2, STEP_DEPTH + 2)
                                              : $urandom_range(1, 6);
        span = 0;
        for (int i = 0; i < n_steps; i++) begin
            dur = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            if (i < STEP_DEPTH) begin
                span += (dur == 0) ? longint'(1) : longint'(dur);
            end
            send_item(make_item(CMD_ADD, any_sel(), dur, 16'($urandom)));
        end
        case ($urandom_range(0, 9))
            0:       reps = 0;
            1:       reps = $urandom_range(1, 16'hFFFF);
            default: reps = $urandom_range(1, 3);
        endcase
        send_item(make_item(CMD_START, any_sel(), 16'($urandom), 16'(reps)));
        // enough ticks to run out the sequence, capped for long ones
        n_ticks = span * longint'(reps) + longint'($urandom_range(0, 3));
        if (n_ticks > 60) begin
            n_ticks = longint'($urandom_range(20, 60));
        end
        for (longint t = 0; t < n_ticks; t++) begin
            case ($urandom_range(0, 39))
                0: send_item(make_item(CMD_ADD, any_sel(), 16'($urandom_range(0, 2)),
                                       16'($urandom)));
                1: send_item(make_item(CMD_START, any_sel(), 16'($urandom),
                                       16'($urandom_range(1, 2))));
                2: send_item(make_item(CMD_LIGHT, any_sel(), 16'($urandom), 16'($urandom)));
                default: send_item(make_item(CMD_TICK, any_sel(), 16'($urandom),
                                             16'($urandom)));
            endcase
        end
    endtask

    // random programs in phases, new settings between phases, last phase without gaps
    task automatic test_random_programs();
        int phase_end;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                idling_on <= 1'b0;
            end else begin
                idling_on <= ($urandom_range(0, 3) != 0);
            end
            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < phase_end) begin
                run_program();
            end
            if (ph != RANDOM_PHASES - 1) begin
                drain_results();
                write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        drop_sequence();
        led_cfg.on_level       = 1'b1;
        led_cfg.first_present  = 1'b1;
        led_cfg.second_present = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_config(1'b1, 1'b1, 1'b1);
        test_directed_cases();
        test_output_levels();
        drain_results();
        write_config(1'b1, 1'b1, 1'b1);
        test_random_programs();
        idling_on <= 1'b0;
        drain_results();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/lbs_pkg.sv
sv/lbs_step_ram.sv
sv/lbs_cfg_regs.sv
sv/lbs_seq_ctrl.sv
sv/led_blink_step_sequencer.sv
tb/tb.sv
